// ===== rtl/vtdi_pkg.sv =====
`default_nettype none

package vtdi_pkg;

   // Width of the result index field.
   localparam int UNIQUE_W = 12;

   // Width of the mesh generation mark kept with every slot.
   localparam int EPOCH_W = 8;

endpackage

`default_nettype wire

// ===== rtl/vertex_triple_dedup_index_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  new_mesh, position, normal, texcoord index
// rsp       out        rsp_valid/rsp_ready  unique_index, is_new, overflow
//
// A transaction reads its home slot and then each further slot that it probes, passing
// through ST_READ and ST_CMP for every slot; the open-addressed hash table has one read port.
// After reset a clearing pass over every slot runs before req_ready rises.
// Every 255th new-mesh transaction wraps the 8-bit mesh mark and starts the same pass.
// A result waits in the output register while rsp_ready is low; the next transaction
// may be taken meanwhile and holds its final compare until the register frees up.

module vertex_triple_dedup_index_unit #(
   parameter int TABLE_DEPTH = 4096,
   parameter int INDEX_BITS  = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_new_mesh,
   input  wire logic        [INDEX_BITS-1:0]   req_position_idx,
   input  wire logic signed [INDEX_BITS:0]     req_normal_idx,
   input  wire logic signed [INDEX_BITS:0]     req_texcoord_idx,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [vtdi_pkg::UNIQUE_W-1:0]       rsp_unique_index,
   output logic                                rsp_is_new,
   output logic                                rsp_overflow
);

   import vtdi_pkg::*;

   localparam int SB     = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ATTR_W = INDEX_BITS + 1;
   localparam int DATA_W = EPOCH_W + SB + 2 * ATTR_W + INDEX_BITS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CMP   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [SB-1:0]         clr_addr_ff, clr_addr_in;
   logic                  item_ff, item_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [ATTR_W-1:0]     nrm_ff, nrm_in;
   logic [ATTR_W-1:0]     tex_ff, tex_in;
   logic [SB-1:0]         addr_ff, addr_in;
   logic [SB-1:0]         probe_ff, probe_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [UNIQUE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                  rsp_new_ff, rsp_new_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [SB-1:0]         req_hash;
   logic                  req_fire;
   logic                  wr_en;
   logic [SB-1:0]         wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic                  rd_en;
   logic [DATA_W-1:0]     rd_data;

   logic [EPOCH_W-1:0]    slot_epoch;
   logic [SB-1:0]         slot_idx;
   logic [ATTR_W-1:0]     slot_tex;
   logic [ATTR_W-1:0]     slot_nrm;
   logic [INDEX_BITS-1:0] slot_pos;
   logic                  slot_live;
   logic                  slot_hit;
   logic                  last_probe;
   logic                  table_full;
   logic                  probe_done;
   logic                  out_free;
   logic                  finish;
   logic                  insert;
   logic [SB-1:0]         result_idx;
   logic [SB+UNIQUE_W-1:0] result_wide;

   // Home slot of the incoming triple.
   vtdi_hash #(
      .INDEX_BITS (INDEX_BITS),
      .SLOT_BITS  (SB)
   ) u_hash (
      .pos_key   (req_position_idx),
      .nrm_key   (req_normal_idx),
      .tex_key   (req_texcoord_idx),
      .slot_hash (req_hash)
   );

   // Slot store: mesh mark, dense index and the stored triple.
   vtdi_slot_ram #(
      .ADDR_W (SB),
      .DATA_W (DATA_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Slot fields and the compare against the held triple.
   assign {slot_epoch, slot_idx, slot_tex, slot_nrm, slot_pos} = rd_data;
   assign slot_live  = (slot_epoch == epoch_ff);
   assign slot_hit   = slot_live && (slot_pos == pos_ff) && (slot_nrm == nrm_ff)
                       && (slot_tex == tex_ff);
   assign last_probe = (probe_ff == {SB{1'b1}});
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign probe_done = slot_hit || !slot_live || last_probe;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == ST_CMP) && probe_done && out_free;
   assign insert     = finish && !slot_hit && !slot_live && !table_full;

   // Dense index of the result: the stored index on a hit, the next index on an insert, else zero.
   always_comb begin
      if (slot_hit) begin
         result_idx = slot_idx;
      end else if (!slot_live && !table_full) begin
         result_idx = count_ff[SB-1:0];
      end else begin
         result_idx = '0;
      end
   end
   assign result_wide = {{UNIQUE_W{1'b0}}, result_idx};

   // Memory port control: the clearing pass writes a dead mark, an insert the new entry.
   assign rd_en   = (state_ff == ST_READ);
   assign wr_en   = insert || (state_ff == ST_CLEAR);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? '0
                  : {epoch_ff, count_ff[SB-1:0], tex_ff, nrm_ff, pos_ff};

   // Sequencer for clearing, probing and result hand-off.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      nrm_in       = nrm_ff;
      tex_in       = tex_ff;
      addr_in      = addr_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {SB{1'b1}}) begin
               state_in = item_ff ? ST_READ : ST_IDLE;
               item_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               pos_in   = req_position_idx;
               nrm_in   = req_normal_idx;
               tex_in   = req_texcoord_idx;
               addr_in  = req_hash;
               probe_in = '0;
               state_in = ST_READ;
               if (req_new_mesh) begin
                  count_in = '0;
                  // A wrapping mesh mark could revive stale slots, so sweep first.
                  if (epoch_ff == {EPOCH_W{1'b1}}) begin
                     epoch_in    = EPOCH_W'(1);
                     clr_addr_in = '0;
                     item_in     = 1'b1;
                     state_in    = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!probe_done) begin
               addr_in  = addr_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = ST_READ;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = result_wide[UNIQUE_W-1:0];
               rsp_new_in   = insert;
               rsp_ovf_in   = !slot_hit && table_full;
               state_in     = ST_IDLE;
               if (insert) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         item_ff      <= 1'b0;
         epoch_ff     <= EPOCH_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         item_ff      <= item_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      nrm_ff       <= nrm_in;
      tex_ff       <= tex_in;
      addr_ff      <= addr_in;
      probe_ff     <= probe_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // The live mesh mark is never the mark that the clearing pass writes.
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("mesh mark is zero");

   // An insert grows the table by exactly one entry.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance the entry count");

   // A new result is loaded only when the output register is free.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_index_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/vtdi_hash.sv =====
`default_nettype none

module vtdi_hash #(
   parameter int INDEX_BITS = 24,
   parameter int SLOT_BITS  = 12
) (
   input  wire logic [INDEX_BITS-1:0] pos_key,
   input  wire logic [INDEX_BITS:0]   nrm_key,
   input  wire logic [INDEX_BITS:0]   tex_key,
   output logic      [SLOT_BITS-1:0]  slot_hash
);

   // Each attribute is folded onto the slot address with its own rotation, so that
   // triples with equal position, normal and texture indices do not cancel out.
   localparam int ROT_N = SLOT_BITS / 2;
   localparam int ROT_T = (SLOT_BITS + 2) / 3;

   always_comb begin
      slot_hash = '0;
      for (int i = 0; i < INDEX_BITS; i++) begin
         slot_hash[i % SLOT_BITS] = slot_hash[i % SLOT_BITS] ^ pos_key[i];
      end
      for (int i = 0; i < INDEX_BITS + 1; i++) begin
         slot_hash[(i + ROT_N) % SLOT_BITS] =
            slot_hash[(i + ROT_N) % SLOT_BITS] ^ nrm_key[i];
         slot_hash[(i + ROT_T) % SLOT_BITS] =
            slot_hash[(i + ROT_T) % SLOT_BITS] ^ tex_key[i];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vtdi_slot_ram.sv =====
`default_nettype none

module vtdi_slot_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 94
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/vertex_triple_dedup_index_unit_tb.sv =====
`default_nettype none

module vertex_triple_dedup_index_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vtdi_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int POS_W       = 24;
   localparam int ATTR_W      = POS_W + 1;

   // A negative attribute index marks a missing normal or texture coordinate.
   localparam logic [ATTR_W-1:0] NO_ATTR   = '1;
   localparam logic [ATTR_W-1:0] ATTR_MAX  = 25'h0FF_FFFF;
   localparam logic [ATTR_W-1:0] ATTR_MOST_NEGATIVE = 25'h100_0000;
   localparam logic [POS_W-1:0]  POS_MAX   = '1;

   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      logic              new_mesh;
      logic [POS_W-1:0]  position;
      logic [ATTR_W-1:0] normal;
      logic [ATTR_W-1:0] texcoord;
   } corner_type;

   typedef struct packed {
      logic [UNIQUE_W-1:0] unique_index;
      logic                is_new;
      logic                overflow;
   } dedup_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_new_mesh     = 1'b0;
   logic [POS_W-1:0]         req_position_idx = '0;
   logic signed [ATTR_W-1:0] req_normal_idx   = '0;
   logic signed [ATTR_W-1:0] req_texcoord_idx = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [UNIQUE_W-1:0]      rsp_unique_index;
   logic                     rsp_is_new;
   logic                     rsp_overflow;

   // Idle percentages for the two sides of the block.
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;

   // Predicted contents of the triple table for the current mesh.
   logic [POS_W-1:0]  mesh_pos [TABLE_DEPTH];
   logic [ATTR_W-1:0] mesh_nrm [TABLE_DEPTH];
   logic [ATTR_W-1:0] mesh_tex [TABLE_DEPTH];
   int                mesh_entries = 0;

   dedup_result_type pending_results[$];

   int mismatch_count = 0;
   int corners_sent   = 0;
   int meshes_started = 0;
   int results_seen   = 0;
   int inserted_seen  = 0;
   int reused_seen    = 0;
   int overflow_seen  = 0;

   vertex_triple_dedup_index_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_new_mesh     (req_new_mesh),
      .req_position_idx (req_position_idx),
      .req_normal_idx   (req_normal_idx),
      .req_texcoord_idx (req_texcoord_idx),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_unique_index (rsp_unique_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is stopped here if the block hangs.
   initial begin
      #1_000_000_000;
      $display("vertex_triple_dedup_index_unit_tb failed");
      $finish;
   end

   // The receiver stalls at random, according to the current idle percentage.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Looks a triple up in the predicted table and updates it as the block should.
   function automatic dedup_result_type predict_lookup(corner_type c);
      dedup_result_type r;
      int hit;
      hit = -1;
      if (c.new_mesh) mesh_entries = 0;
      for (int i = 0; i < mesh_entries && hit < 0; i++) begin
         if (mesh_pos[i] == c.position && mesh_nrm[i] == c.normal &&
             mesh_tex[i] == c.texcoord) hit = i;
      end
      if (hit >= 0) begin
         r = '{unique_index: UNIQUE_W'(hit), is_new: 1'b0, overflow: 1'b0};
      end else if (mesh_entries >= TABLE_DEPTH) begin
         r = '{unique_index: '0, is_new: 1'b0, overflow: 1'b1};
      end else begin
         mesh_pos[mesh_entries] = c.position;
         mesh_nrm[mesh_entries] = c.normal;
         mesh_tex[mesh_entries] = c.texcoord;
         r = '{unique_index: UNIQUE_W'(mesh_entries), is_new: 1'b1, overflow: 1'b0};
         mesh_entries++;
      end
      return r;
   endfunction

   function automatic corner_type corner(logic nm, logic [POS_W-1:0] p,
                                         logic [ATTR_W-1:0] n, logic [ATTR_W-1:0] t);
      corner_type c;
      c = '{new_mesh: nm, position: p, normal: n, texcoord: t};
      return c;
   endfunction

   // Attribute index: mostly valid indices, with missing and odd negative values mixed in.
   function automatic logic [ATTR_W-1:0] random_attr();
      logic [31:0] bits;
      logic [ATTR_W-1:0] a;
      bits = $urandom();
      case ($urandom_range(19)) inside
         [0:2]:   a = NO_ATTR;
         3:       a = {1'b1, bits[POS_W-1:0]};
         4:       a = '0;
         5:       a = ATTR_MAX;
         [6:9]:   a = ATTR_W'($urandom_range(63));
         default: a = {1'b0, bits[POS_W-1:0]};
      endcase
      return a;
   endfunction

   function automatic corner_type random_corner();
      logic [31:0] bits;
      corner_type c;
      bits = $urandom();
      c.new_mesh = 1'b0;
      case ($urandom_range(9)) inside
         0:       c.position = '0;
         1:       c.position = POS_MAX;
         [2:4]:   c.position = POS_W'($urandom_range(255));
         default: c.position = bits[POS_W-1:0];
      endcase
      c.normal   = random_attr();
      c.texcoord = random_attr();
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sends one corner, with random idle cycles first, and records its prediction.
   task automatic send_corner(input corner_type c);
      dedup_result_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_new_mesh     <= c.new_mesh;
      req_position_idx <= c.position;
      req_normal_idx   <= c.normal;
      req_texcoord_idx <= c.texcoord;
      do @(posedge clock); while (!req_ready);
      predicted = predict_lookup(c);
      pending_results = {pending_results, predicted};
      corners_sent++;
      if (c.new_mesh) meshes_started++;
   endtask

   // Holds the sender back until every predicted result has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Compares each accepted transaction on the result channel with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      dedup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no corner waiting",
                                      results_seen));
         end else begin
            want = pending_results.pop_front();
            if (rsp_unique_index !== want.unique_index)
               report_mismatch($sformatf("result %0d: unique_index %0d, expected %0d",
                                         results_seen, rsp_unique_index, want.unique_index));
            if (rsp_is_new !== want.is_new)
               report_mismatch($sformatf("result %0d: is_new %b, expected %b",
                                         results_seen, rsp_is_new, want.is_new));
            if (rsp_overflow !== want.overflow)
               report_mismatch($sformatf("result %0d: overflow %b, expected %b",
                                         results_seen, rsp_overflow, want.overflow));
            if (want.overflow) overflow_seen++;
            else if (want.is_new) inserted_seen++;
            else reused_seen++;
         end
      end
   end

   // Field extremes, missing attributes, distinct negative values and mesh restarts.
   task automatic test_directed_corners();
      tx_idle_pct = 19;
      rx_idle_pct = 82;
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, '0, NO_ATTR - 1'b1, NO_ATTR));
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR - 1'b1));
      send_corner(corner(1'b0, '0, ATTR_MOST_NEGATIVE, ATTR_MAX));
      send_corner(corner(1'b0, POS_MAX, ATTR_MAX, ATTR_MAX));
      send_corner(corner(1'b0, POS_MAX, '0, '0));
      send_corner(corner(1'b0, '0, '0, '0));
      send_corner(corner(1'b0, '0, NO_ATTR - 1'b1, NO_ATTR));
      send_corner(corner(1'b0, 24'hAAAAAA, 25'h0555555, 25'h1AAAAAA));
      send_corner(corner(1'b0, 24'h555555, 25'h1AAAAAA, 25'h0555555));
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, POS_MAX, ATTR_MAX, ATTR_MAX));
      // A new mesh forgets every earlier triple, even the one it carries.
      send_corner(corner(1'b1, POS_MAX, ATTR_MAX, ATTR_MAX));
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, POS_MAX, ATTR_MAX, ATTR_MAX));
      send_corner(corner(1'b1, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b1, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, '0, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, 24'h000001, NO_ATTR, NO_ATTR));
      send_corner(corner(1'b0, 24'h000001, 25'h0000001, NO_ATTR));
      send_corner(corner(1'b0, 24'h000001, 25'h0000001, 25'h0000001));
      send_corner(corner(1'b0, 24'h000001, NO_ATTR, NO_ATTR));
      wait_for_results();
   endtask

   // Meshes of random size whose corners mostly repeat earlier triples of the same mesh.
   task automatic test_random_meshes(input int n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
      corner_type pool[$];
      corner_type c;
      int sent;
      int mesh_len;
      int roll;
      bit start_mesh;
      sent = 0;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (sent < n_items) begin
         start_mesh = (sent == 0) || ($urandom_range(99) < 85);
         mesh_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
         if (start_mesh) pool.delete();
         for (int k = 0; k < mesh_len && sent < n_items; k++) begin
            roll = $urandom_range(99);
            if (pool.size() != 0 && roll < 55) begin
               c = pool[$urandom_range(pool.size() - 1)];
            end else if (pool.size() != 0 && roll < 65) begin
               // A near miss: one bit differs from a stored triple.
               c = pool[$urandom_range(pool.size() - 1)];
               case ($urandom_range(2))
                  0: c.position[$urandom_range(POS_W - 1)] ^= 1'b1;
                  1: c.normal[$urandom_range(ATTR_W - 1)] ^= 1'b1;
                  default: c.texcoord[$urandom_range(ATTR_W - 1)] ^= 1'b1;
               endcase
               pool = {pool, c};
            end else begin
               c = random_corner();
               pool = {pool, c};
            end
            c.new_mesh = (k == 0 && start_mesh) || ($urandom_range(99) < 2);
            send_corner(c);
            sent++;
            if (sent == n_items / 2) wait_for_results();
         end
      end
      wait_for_results();
   endtask

   // Hundreds of tiny meshes, enough to wrap the block's mesh counter.
   task automatic test_mesh_mark_wrap(input int n_meshes);
      corner_type c;
      tx_idle_pct = 82;
      rx_idle_pct = 19;
      for (int m = 0; m < n_meshes; m++) begin
         c = random_corner();
         c.new_mesh = 1'b1;
         send_corner(c);
         if ($urandom_range(3) == 0) begin
            c.new_mesh = 1'b0;
            if ($urandom_range(1) == 1) c = random_corner();
            send_corner(c);
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_meshes(50, 19, 82);
      test_mesh_mark_wrap(260);
      test_random_meshes(50, 82, 19);
      test_random_meshes(50, 0, 0);

      wait_for_results();
      repeat (100) @(posedge clock);

      $display("Sent %0d corners in %0d new meshes; %0d results checked.",
               corners_sent, meshes_started, results_seen);
      $display("Results: %0d inserted, %0d found again, %0d rejected on a full table.",
               inserted_seen, reused_seen, overflow_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("vertex_triple_dedup_index_unit_tb passed");
      end else begin
         $display("vertex_triple_dedup_index_unit_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vtdi_pkg.sv
rtl/vtdi_hash.sv
rtl/vtdi_slot_ram.sv
rtl/vertex_triple_dedup_index_unit.sv
test/vertex_triple_dedup_index_unit_tb.sv
